FILE: hw/rtl/gsm_pkg.sv
package gsm_pkg;

  // sizes of the pool
  localparam int unsigned SLOTS     = 256;
  localparam int unsigned SLOT_BITS = $clog2(SLOTS);
  localparam int unsigned CNT_BITS  = $clog2(SLOTS + 1);
  localparam int unsigned ID_BITS   = 16;
  localparam int unsigned ID_COUNT  = 1 << ID_BITS;
  localparam int unsigned GEN_BITS  = 16;
  localparam int unsigned CAP_BITS  = 9;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

  // command codes
  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_INUSE    = 3'd2;
  localparam logic [2:0] ST_UNMAPPED = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] object_id;
    logic [15:0] query_generation;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot_index;
    logic [15:0] assigned_id;
    logic [15:0] slot_generation_out;
    logic        move_valid;
    logic [7:0]  move_from;
    logic [7:0]  move_to;
    logic [8:0]  active_count;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // take the input beat and issue the first reads
    logic read;   // issue the reads at the mapped slot
    logic exec;   // decide, write the tables and load the result
  } ctrl_t;

endpackage

FILE: hw/rtl/gsm_ctrl.sv
module gsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gsm_pkg::ctrl_t ctrl_o
);
  import gsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e st_q, st_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, do_exec;

  // handshake decode
  assign in_ready_o  = (st_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign do_exec     = (st_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign ctrl_o.load = accept;
  assign ctrl_o.read = (st_q == ST_READ);
  assign ctrl_o.exec = do_exec;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) st_d = ST_READ;
      ST_READ: st_d = ST_EXEC;
      ST_EXEC: if (do_exec) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  // result beat occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (do_exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // sequencing checks
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> st_q == ST_READ) else $error("accepted beat did not start reads");

  a_read_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_READ |=> st_q == ST_EXEC) else $error("read phase not followed by exec");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q == ST_EXEC)) else $error("result without exec");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && st_q == ST_EXEC) |=> st_q == ST_EXEC)
    else $error("pending result overwritten");

endmodule

FILE: hw/rtl/gsm_datapath.sv
module gsm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gsm_pkg::ctrl_t                ctrl_i,
  input  gsm_pkg::in_t                  in_data_i,
  output gsm_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gsm_pkg::CAP_BITS-1:0]  cfg_data_i
);
  import gsm_pkg::*;

  // tables: the id map needs no clearing, membership is confirmed by the slot owner
  bit   [SLOT_BITS-1:0] map_mem   [ID_COUNT];
  logic [ID_BITS-1:0]   owner_mem [SLOTS];
  logic [GEN_BITS-1:0]  gen_mem   [SLOTS];
  logic [SLOTS-1:0]     gen_vld_q;

  logic [CAP_BITS-1:0]  cap_q;
  logic [CNT_BITS-1:0]  active_q, active_d;
  logic [ID_BITS-1:0]   next_id_q;
  in_t                  in_q;
  out_t                 out_q, out_d;

  logic [SLOT_BITS-1:0] map_rd_q;
  logic [ID_BITS-1:0]   owner_rd_q, owner_last_q;
  logic [GEN_BITS-1:0]  gen_rd_q, gen_a_q;
  logic                 gen_rv_q;

  logic [SLOT_BITS-1:0] act_idx, last_idx, slot_s;
  logic [ID_BITS-1:0]   map_raddr, aid;
  logic [SLOT_BITS-1:0] tab_raddr_gen, tab_raddr_own;
  logic [CNT_BITS-1:0]  limit;
  logic [GEN_BITS-1:0]  gen_s, gen_a_rd, gen_new;
  logic                 hit, full, rd_en;

  logic                 own_we, gen_we, map_we;
  logic [SLOT_BITS-1:0] tab_waddr, map_wdata;
  logic [ID_BITS-1:0]   own_wdata, map_waddr;
  logic [GEN_BITS-1:0]  gen_wdata;

  // address decode
  assign act_idx   = active_q[SLOT_BITS-1:0];
  assign last_idx  = SLOT_BITS'(active_q - CNT_BITS'(1));
  assign map_raddr = (in_data_i.cmd == CMD_CREATE) ? next_id_q : in_data_i.object_id;
  assign rd_en     = ctrl_i.load || ctrl_i.read;

  assign tab_raddr_gen = ctrl_i.read ? map_rd_q :
                         ((in_data_i.cmd == CMD_CREATE) ? act_idx : last_idx);
  assign tab_raddr_own = ctrl_i.read ? map_rd_q : last_idx;

  // registered table reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      map_rd_q <= map_mem[map_raddr];
      in_q     <= in_data_i;
    end
    if (rd_en) begin
      gen_rd_q   <= gen_mem[tab_raddr_gen];
      gen_rv_q   <= gen_vld_q[tab_raddr_gen];
      owner_rd_q <= owner_mem[tab_raddr_own];
    end
    if (ctrl_i.read) begin
      gen_a_q      <= gen_a_rd;
      owner_last_q <= owner_rd_q;
    end
  end

  // read data of never-written generations counts as zero
  assign gen_a_rd = gen_rv_q ? gen_rd_q : '0;
  assign gen_s    = gen_rv_q ? gen_rd_q : '0;
  assign gen_new  = gen_a_q + GEN_BITS'(1);

  // decision
  assign aid    = (in_q.cmd == CMD_CREATE) ? next_id_q : in_q.object_id;
  assign slot_s = map_rd_q;
  assign hit    = ({1'b0, slot_s} < active_q) && (owner_rd_q == aid);
  assign limit  = (cap_q < CAP_BITS'(SLOTS)) ? CNT_BITS'(cap_q) : CNT_BITS'(SLOTS);
  assign full   = (active_q >= limit);

  always_comb begin
    out_d             = '0;
    out_d.status      = ST_OK;
    out_d.assigned_id = aid;
    active_d          = active_q;
    own_we            = 1'b0;
    gen_we            = 1'b0;
    map_we            = 1'b0;
    tab_waddr         = slot_s;
    own_wdata         = owner_last_q;
    gen_wdata         = gen_a_q;
    map_waddr         = owner_last_q;
    map_wdata         = slot_s;
    unique case (in_q.cmd)
      CMD_CREATE: begin
        priority if (full) begin
          out_d.status = ST_FULL;
        end else if (hit) begin
          out_d.status = ST_INUSE;
        end else begin
          out_d.slot_index          = act_idx;
          out_d.slot_generation_out = gen_new;
          active_d  = active_q + CNT_BITS'(1);
          own_we    = 1'b1;
          gen_we    = 1'b1;
          map_we    = 1'b1;
          tab_waddr = act_idx;
          own_wdata = aid;
          gen_wdata = gen_new;
          map_waddr = aid;
          map_wdata = act_idx;
        end
      end
      CMD_REMOVE: begin
        if (!hit) begin
          out_d.status = ST_UNMAPPED;
        end else begin
          out_d.slot_index          = slot_s;
          out_d.slot_generation_out = gen_s;
          active_d = active_q - CNT_BITS'(1);
          // compaction move of the last slot
          if (last_idx != slot_s) begin
            out_d.move_valid = 1'b1;
            out_d.move_from  = last_idx;
            out_d.move_to    = slot_s;
            own_we = 1'b1;
            gen_we = 1'b1;
            map_we = 1'b1;
          end
        end
      end
      CMD_LOOKUP: begin
        priority if (!hit) begin
          out_d.status = ST_UNMAPPED;
        end else if (gen_s != in_q.query_generation) begin
          out_d.status = ST_STALE;
        end else begin
          out_d.slot_index          = slot_s;
          out_d.slot_generation_out = gen_s;
        end
      end
      default: begin
        out_d.status = ST_UNMAPPED;
      end
    endcase
    out_d.active_count = active_d;
  end

  // table writes and result load
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && own_we) owner_mem[tab_waddr] <= own_wdata;
    if (ctrl_i.exec && gen_we) gen_mem[tab_waddr]   <= gen_wdata;
    if (ctrl_i.exec && map_we) map_mem[map_waddr]   <= map_wdata;
    if (ctrl_i.exec)           out_q                <= out_d;
  end

  // pool state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      active_q  <= '0;
      next_id_q <= '0;
      gen_vld_q <= '0;
    end else if (cfg_we_i) begin
      cap_q     <= cfg_data_i;
      active_q  <= '0;
      gen_vld_q <= '0;
    end else if (ctrl_i.exec) begin
      active_q <= active_d;
      if (gen_we) gen_vld_q[tab_waddr] <= 1'b1;
      if (in_q.cmd == CMD_CREATE && map_we) next_id_q <= next_id_q + ID_BITS'(1);
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hw/rtl/generational_slot_map_top.sv
// Densely packed handle pool with per-slot generations. Each command beat passes
// through accept with id-map read, then slot read, then decide and write, an order
// set by the chain of registered reads through the id map and then the slot tables; a
// result beat may wait at the output while the next command is taken. Creates fill the
// slot after the last active one, removes move the last slot into the freed one and
// report that move for an outside payload store. A capacity write empties the pool
// with no clearing pass; the id counter is kept.
module generational_slot_map_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  gsm_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gsm_pkg::out_t                 out_data_o,
  input  logic                          cfg_we_i,
  input  logic [gsm_pkg::CAP_BITS-1:0]  cfg_data_i
);
  import gsm_pkg::*;

  ctrl_t ctrl;

  // sequencer
  gsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // tables and result register
  gsm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

endmodule

FILE: verif/generational_slot_map_top_tb.sv
`timescale 1ns / 100ps

module generational_slot_map_top_tb;
  import gsm_pkg::*;

  localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;

  // pool tracker: own copy of the id map and slot tables, expected beats in order
  class slot_pool_tracker;
    bit          id_live [ID_COUNT];
    logic [7:0]  id_slot [ID_COUNT];
    logic [15:0] owner [SLOTS];
    logic [15:0] gen [SLOTS];
    int unsigned active;
    logic [15:0] next_id;
    int unsigned cap;
    out_t        outcome_q [$];
    int unsigned errors;

    function new();
      foreach (owner[s]) owner[s] = '0;
      next_id = '0;
      errors  = 0;
      set_capacity(CAP_RESET);
    endfunction

    // a capacity write empties the pool but keeps the id counter
    function void set_capacity(logic [8:0] v);
      cap = v;
      foreach (id_live[i]) begin
        id_live[i] = 1'b0;
        id_slot[i] = '0;
      end
      foreach (gen[s]) gen[s] = '0;
      active = 0;
    endfunction

    function int unsigned limit();
      return (cap < SLOTS) ? cap : SLOTS;
    endfunction

    function bit find_slot(input logic [15:0] id, output logic [7:0] s);
      s = id_slot[id];
      return id_live[id] && (s < active);
    endfunction

    function out_t predict_outcome(in_t c);
      out_t        r;
      logic [7:0]  s;
      logic [7:0]  last;
      logic [15:0] moved;
      r = '0;
      r.status = ST_OK;
      r.assigned_id = c.object_id;
      case (c.cmd)
        CMD_CREATE: begin
          r.assigned_id = next_id;
          if (active >= limit()) begin
            r.status = ST_FULL;
          end else if (id_live[next_id]) begin
            r.status = ST_INUSE;
          end else begin
            s = 8'(active);
            owner[s] = next_id;
            gen[s] = gen[s] + 16'd1;
            r.slot_index = s;
            r.slot_generation_out = gen[s];
            id_live[next_id] = 1'b1;
            id_slot[next_id] = s;
            active++;
            next_id++;
          end
        end
        CMD_REMOVE: begin
          if (!find_slot(c.object_id, s)) begin
            r.status = ST_UNMAPPED;
          end else begin
            r.slot_index = s;
            r.slot_generation_out = gen[s];
            active--;
            last = 8'(active);
            // compaction: last slot takes the freed place
            if (last != s) begin
              moved = owner[last];
              owner[s] = owner[last];
              gen[s] = gen[last];
              id_slot[moved] = s;
              id_live[moved] = 1'b1;
              r.move_valid = 1'b1;
              r.move_from = last;
              r.move_to = s;
            end
            id_live[c.object_id] = 1'b0;
            id_slot[c.object_id] = '0;
          end
        end
        CMD_LOOKUP: begin
          if (!find_slot(c.object_id, s)) begin
            r.status = ST_UNMAPPED;
          end else if (gen[s] != c.query_generation) begin
            r.status = ST_STALE;
          end else begin
            r.slot_index = s;
            r.slot_generation_out = gen[s];
          end
        end
        default: begin
          r.status = ST_UNMAPPED;
        end
      endcase
      r.active_count = 9'(active);
      return r;
    endfunction

    function void note_command(in_t c);
      outcome_q.push_back(predict_outcome(c));
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (outcome_q.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("slot_index", 16'(want.slot_index), 16'(got.slot_index));
      compare_field("assigned_id", want.assigned_id, got.assigned_id);
      compare_field("slot_generation_out", want.slot_generation_out,
                    got.slot_generation_out);
      compare_field("move_valid", 16'(want.move_valid), 16'(got.move_valid));
      compare_field("move_from", 16'(want.move_from), 16'(got.move_from));
      compare_field("move_to", 16'(want.move_to), 16'(got.move_to));
      compare_field("active_count", 16'(want.active_count), 16'(got.active_count));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CAP_BITS-1:0] cfg_data_i  = '0;

  bit                  idle_on     = 1'b1;
  bit                  hold_req    = 1'b0;
  int unsigned         cycles      = 0;

  slot_pool_tracker tracker = new();

  generational_slot_map_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request, check each beat
  initial begin
    int unsigned gap;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      tracker.check_result(out_data_o);
    end
  end

  function automatic in_t make_cmd(logic [1:0] op, logic [15:0] id, logic [15:0] g);
    in_t c;
    c.cmd = op;
    c.object_id = id;
    c.query_generation = g;
    return c;
  endfunction

  // mostly live ids with the right generation, some noise
  function automatic in_t random_command(int unsigned create_pct);
    int unsigned r;
    int unsigned s;
    int unsigned pct;
    logic [15:0] g;
    in_t         c;
    c = make_cmd(CMD_CREATE, 16'($urandom), 16'($urandom));
    r = $urandom_range(0, 99);
    pct = (tracker.active >= tracker.limit()) ? 25 : create_pct;
    if (r < 3) begin
      c.cmd = CMD_UNKNOWN;
    end else if (r < 9) begin
      c.cmd = (r < 6) ? CMD_REMOVE : CMD_LOOKUP;
    end else if (tracker.active != 0 && $urandom_range(0, 99) >= pct) begin
      s = $urandom_range(0, tracker.active - 1);
      c.object_id = tracker.owner[s];
      g = tracker.gen[s];
      if ($urandom_range(0, 1) == 1) begin
        c.cmd = CMD_REMOVE;
      end else begin
        c.cmd = CMD_LOOKUP;
        c.query_generation = ($urandom_range(0, 4) != 0) ? g
                           : g ^ (16'd1 << $urandom_range(0, 15));
      end
    end
    return c;
  endfunction

  task automatic send_command(input in_t c);
    int unsigned gap;
    in_data_i  <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_command(c);
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // only written with the pool quiet
  task automatic write_capacity(input logic [8:0] v);
    in_valid_i <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    tracker.set_capacity(v);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned create_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_command(random_command(create_pct));
    end
  endtask

  initial begin
    logic [15:0] id;
    logic [15:0] anchor;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pool: lookup, remove and unknown command all miss
    send_command(make_cmd(CMD_LOOKUP, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_REMOVE, 16'hFFFF, 16'h0000));
    send_command(make_cmd(CMD_UNKNOWN, 16'hFFFF, 16'hFFFF));
    // ids 0, 1, 2 into slots 0, 1, 2
    repeat (3) send_command(make_cmd(CMD_CREATE, 16'hFFFF, 16'hFFFF));
    send_command(make_cmd(CMD_LOOKUP, 16'd0, 16'd1));
    send_command(make_cmd(CMD_LOOKUP, 16'd1, 16'hFFFF));
    // remove from the first slot moves slot 2 down to slot 0
    send_command(make_cmd(CMD_REMOVE, 16'd0, 16'd0));
    send_command(make_cmd(CMD_LOOKUP, 16'd2, 16'd1));
    send_command(make_cmd(CMD_LOOKUP, 16'd0, 16'd1));
    // removing the last slot needs no move
    send_command(make_cmd(CMD_REMOVE, 16'd1, 16'd0));
    send_command(make_cmd(CMD_REMOVE, 16'd2, 16'd0));

    // zero capacity refuses every create
    write_capacity(9'd0);
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    write_capacity(9'd1);
    id = tracker.next_id;
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_REMOVE, id, 16'h0000));

    // small pool: slot 1 reused with rising generations, then full and a move
    write_capacity(9'd2);
    idle_on = 1'b0;
    anchor = tracker.next_id;
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    repeat (4) begin
      id = tracker.next_id;
      send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
      send_command(make_cmd(CMD_LOOKUP, id, tracker.gen[1]));
      send_command(make_cmd(CMD_REMOVE, id, 16'h0000));
    end
    id = tracker.next_id;
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_CREATE, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_LOOKUP, anchor, 16'd1));
    send_command(make_cmd(CMD_REMOVE, anchor, 16'h0000));
    send_command(make_cmd(CMD_LOOKUP, id, tracker.gen[0]));

    // random traffic over several capacities
    write_capacity(9'd511);
    run_random(400, 92);
    write_capacity(9'd2);
    run_random(150, 50);
    write_capacity(9'd255);
    run_random(350, 90);
    write_capacity(9'($urandom_range(1, 64)));
    run_random(200, 55);

    // output held off while commands keep coming, then random again
    write_capacity(9'd256);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_command(random_command(70));
    run_random(140, 60);

    in_valid_i <= 1'b0;
    while (tracker.outcome_q.size() != 0) @(posedge clk_i);
    idle_on = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/gsm_pkg.sv
hw/rtl/gsm_ctrl.sv
hw/rtl/gsm_datapath.sv
hw/rtl/generational_slot_map_top.sv
verif/generational_slot_map_top_tb.sv
